@@ sv/twlf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// twlf_pkg
// Shared widths, codes and controller/datapath interface types for the
// time-window log FIFO.
// ---------------------------------------------------------------------------
package twlf_pkg;

    localparam int ID_W    = 31;
    localparam int STAMP_W = 31;
    localparam int OCC_W   = 7;
    localparam int REP_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 2;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 31;

    localparam logic [STAMP_W-1:0] WINDOW_RST = 31'd3600;
    localparam logic [REP_W-1:0]   MAXREP_RST = 7'd64;

    // input selector
    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_WINDOW     = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_REPORT = 2'd1;

    typedef struct packed {
        logic accept_rec;   // latch record, append if allowed
        logic accept_list;  // latch list length, start walk at head
        logic pop;          // evict head entry
        logic rd_list;      // RAM read address follows the list walk
        logic load_ack;     // output beat: record acknowledge
        logic load_entry;   // output beat: listed entry
        logic load_empty;   // output beat: empty marker
        logic load_count;   // output beat: occupancy
    } cmd_t;

    typedef struct packed {
        logic evict_go;     // head entry has aged out of the window
        logic n_zero;       // list request has nothing to show
        logic at_last;      // current listed entry is the final one
        logic out_free;     // output register can take a beat
    } stat_t;

endpackage
`default_nettype wire

@@ sv/twlf_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// twlf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module twlf_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/twlf_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// twlf_ctrl
// Sequencer: takes one item at a time, runs the eviction loop and the list
// walk, and schedules output beats.
// ---------------------------------------------------------------------------
module twlf_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [twlf_pkg::FUNC_W-1:0] func,
    output logic                            in_stall,
    input  wire twlf_pkg::stat_t            stat,
    output twlf_pkg::cmd_t                  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_ACK,
        ST_LIST,
        ST_COUNT
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    logic   accept;

    assign in_stall = stall_reg;
    assign accept   = in_valid && !stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        twlf_pkg::FUNC_RECORD:
                        begin
                            cmd.accept_rec = 1'b1;
                            state_next     = ST_EV_RD;
                        end
                        twlf_pkg::FUNC_LIST:
                        begin
                            cmd.accept_list = 1'b1;
                            state_next      = ST_LIST;
                        end
                        twlf_pkg::FUNC_COUNT:
                        begin
                            state_next = ST_COUNT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EV_RD:
            begin
                state_next = ST_EV_CHK;
            end
            ST_EV_CHK:
            begin
                if (stat.evict_go)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_ack = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                cmd.rd_list = 1'b1;
                if (stat.out_free)
                begin
                    if (stat.n_zero)
                    begin
                        cmd.load_empty = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_entry = 1'b1;
                        if (stat.at_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_COUNT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_count = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

`ifndef SYNTHESIS
    // a record always enters the eviction loop through the read wait
    a_rec_to_evict: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == twlf_pkg::FUNC_RECORD |=> state_reg == ST_EV_RD)
        else $error("record did not start eviction");

    // stall is low exactly when the sequencer is idle
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stall_reg == (state_reg != ST_IDLE))
        else $error("stall out of step with sequencer");

    // the list walk only ends on an output beat
    a_list_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST && !stat.out_free |=> state_reg == ST_LIST)
        else $error("list walk left without a beat");
`endif

endmodule
`default_nettype wire

@@ sv/twlf_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// twlf_dp
// Datapath: entry RAM, head/count pointers, latest stamp, config registers,
// eviction compare, list walk counters and the output register.
// ---------------------------------------------------------------------------
module twlf_dp #(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire twlf_pkg::cmd_t                cmd,
    output twlf_pkg::stat_t                    stat,
    input  wire logic                          cfg_valid,
    input  wire logic [twlf_pkg::CFG_A_W-1:0]  cfg_index,
    input  wire logic [twlf_pkg::CFG_D_W-1:0]  cfg_data,
    input  wire logic [twlf_pkg::ID_W-1:0]     log_id,
    input  wire logic [twlf_pkg::STAMP_W-1:0]  stamp,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [twlf_pkg::KIND_W-1:0]        kind,
    output logic [twlf_pkg::ID_W-1:0]          entry_id,
    output logic [twlf_pkg::STAMP_W-1:0]       entry_stamp,
    output logic [twlf_pkg::OCC_W-1:0]         occupancy,
    output logic                               dropped,
    output logic                               last
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = twlf_pkg::ID_W + twlf_pkg::STAMP_W;
    localparam int RW = twlf_pkg::REP_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(FIFO_DEPTH);
    localparam logic [RW-1:0] DEPTH_R   = RW'(FIFO_DEPTH);

    function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    // pointers and state
    logic [PW-1:0]                     head_reg, head_next;
    logic [CW-1:0]                     count_reg;
    logic [twlf_pkg::STAMP_W-1:0]      latest_reg;
    logic                              have_reg;
    logic [twlf_pkg::STAMP_W-1:0]      window_reg;
    logic [RW-1:0]                     maxrep_reg;
    logic [twlf_pkg::STAMP_W-1:0]      item_stamp_reg;
    logic                              drop_reg;
    logic [CW-1:0]                     n_reg;
    logic [CW-1:0]                     idx_reg;
    logic [PW-1:0]                     lptr_reg, lptr_next;

    // output register
    logic                              out_valid_reg;
    logic [twlf_pkg::KIND_W-1:0]       kind_reg;
    logic [twlf_pkg::ID_W-1:0]         id_out_reg;
    logic [twlf_pkg::STAMP_W-1:0]      stamp_out_reg;
    logic [twlf_pkg::OCC_W-1:0]        occ_reg;
    logic                              drop_out_reg;
    logic                              last_reg;

    // RAM
    logic                              ram_we;
    logic [PW-1:0]                     ram_waddr;
    logic [PW-1:0]                     ram_raddr;
    logic [EW-1:0]                     ram_rdata;
    logic [twlf_pkg::ID_W-1:0]         rd_id;
    logic [twlf_pkg::STAMP_W-1:0]      rd_stamp;

    logic                              in_order;
    logic                              is_full;
    logic [SW-1:0]                     tail_sum;
    logic [RW-1:0]                     lim;
    logic [RW-1:0]                     count_r;
    logic [CW-1:0]                     n_calc;
    logic [twlf_pkg::STAMP_W:0]        age_sum;
    logic                              load_any;
    logic                              out_free;

    assign in_order  = !have_reg || (stamp >= latest_reg);
    assign is_full   = (count_reg == FULL_CNT);
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign ram_waddr = (tail_sum >= DEPTH_S) ? PW'(tail_sum - DEPTH_S) : PW'(tail_sum);
    assign ram_we    = cmd.accept_rec && in_order && !is_full;

    assign head_next = cmd.pop ? slot_inc(head_reg) : head_reg;
    assign lptr_next = cmd.load_entry ? slot_inc(lptr_reg) : lptr_reg;
    assign ram_raddr = cmd.rd_list ? lptr_next : head_next;

    assign rd_id    = ram_rdata[EW-1 -: twlf_pkg::ID_W];
    assign rd_stamp = ram_rdata[twlf_pkg::STAMP_W-1:0];

    // report limit: zero acts as one, saturate at the depth
    always_comb
    begin
        priority if (maxrep_reg == '0)
        begin
            lim = RW'(1);
        end
        else if (maxrep_reg > DEPTH_R)
        begin
            lim = DEPTH_R;
        end
        else
        begin
            lim = maxrep_reg;
        end
    end

    assign count_r = RW'(count_reg);
    assign n_calc  = (count_r < lim) ? count_reg : CW'(lim);

    // entry ages out when its stamp + window <= record stamp
    assign age_sum = {1'b0, rd_stamp} + {1'b0, window_reg};

    assign out_free = !out_valid_reg || !out_stall;
    assign load_any = cmd.load_ack || cmd.load_entry || cmd.load_empty || cmd.load_count;

    assign stat.evict_go = (count_reg != '0) && (age_sum <= {1'b0, item_stamp_reg});
    assign stat.n_zero   = (n_reg == '0);
    assign stat.at_last  = (CW'(idx_reg + CW'(1)) == n_reg);
    assign stat.out_free = out_free;

    twlf_ram #(
        .WIDTH (EW),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({log_id, stamp}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            latest_reg    <= '0;
            have_reg      <= 1'b0;
            window_reg    <= twlf_pkg::WINDOW_RST;
            maxrep_reg    <= twlf_pkg::MAXREP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            if (ram_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load_ack)
            begin
                latest_reg <= item_stamp_reg;
                have_reg   <= 1'b1;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    twlf_pkg::CFG_WINDOW:     window_reg <= cfg_data;
                    twlf_pkg::CFG_MAX_REPORT: maxrep_reg <= cfg_data[RW-1:0];
                    default:                  ;
                endcase
            end
            if (load_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept_rec)
        begin
            item_stamp_reg <= stamp;
            drop_reg       <= !(in_order && !is_full);
        end
        if (cmd.accept_list)
        begin
            n_reg    <= n_calc;
            idx_reg  <= '0;
            lptr_reg <= head_reg;
        end
        else
        begin
            lptr_reg <= lptr_next;
            if (cmd.load_entry)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
        if (load_any)
        begin
            kind_reg      <= cmd.load_ack   ? twlf_pkg::KIND_ACK   :
                             cmd.load_entry ? twlf_pkg::KIND_ENTRY :
                             cmd.load_empty ? twlf_pkg::KIND_EMPTY : twlf_pkg::KIND_COUNT;
            id_out_reg    <= cmd.load_entry ? rd_id    : '0;
            stamp_out_reg <= cmd.load_entry ? rd_stamp : '0;
            occ_reg       <= twlf_pkg::OCC_W'(count_reg);
            drop_out_reg  <= cmd.load_ack && drop_reg;
            last_reg      <= !cmd.load_entry || stat.at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign entry_id    = id_out_reg;
    assign entry_stamp = stamp_out_reg;
    assign occupancy   = occ_reg;
    assign dropped     = drop_out_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0 && !ram_we)
        else $error("pop from empty store");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_any |-> out_free)
        else $error("output register overwritten while held");

    a_ack_latest: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_ack |=> have_reg && latest_reg == $past(item_stamp_reg))
        else $error("latest stamp not updated on acknowledge");
`endif

endmodule
`default_nettype wire

@@ sv/time_window_log_fifo.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// time_window_log_fifo
// FIFO of (log id, stamp) records that keeps only the last window of time,
// with list and count requests.
// ---------------------------------------------------------------------------
//
// channel  dir  handshake            payload
// -------  ---  -------------------  ---------------------------------------
// in       in   in_valid / in_stall  func, log_id, stamp
// out      out  out_valid/out_stall  kind, entry_id, entry_stamp, occupancy,
//                                    dropped, last
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. A record runs an append step, one RAM read wait, one
// head compare per evicted entry plus a final one, then the acknowledge
// beat. A list gives one beat per listed entry through the single RAM read
// port, or one empty marker beat; a count gives one occupancy beat. Each beat
// waits while the output register is stalled. Reset clears pointers and
// count and sets the config defaults; the entry RAM needs no clearing.
// cfg_ready is always high; writes go straight to the registers.
// ---------------------------------------------------------------------------
module time_window_log_fifo #(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [twlf_pkg::FUNC_W-1:0]   func,
    input  wire logic [twlf_pkg::ID_W-1:0]     log_id,
    input  wire logic [twlf_pkg::STAMP_W-1:0]  stamp,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [twlf_pkg::KIND_W-1:0]        kind,
    output logic [twlf_pkg::ID_W-1:0]          entry_id,
    output logic [twlf_pkg::STAMP_W-1:0]       entry_stamp,
    output logic [twlf_pkg::OCC_W-1:0]         occupancy,
    output logic                               dropped,
    output logic                               last,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [twlf_pkg::CFG_A_W-1:0]  cfg_index,
    input  wire logic [twlf_pkg::CFG_D_W-1:0]  cfg_data
);

    twlf_pkg::cmd_t  cmd;
    twlf_pkg::stat_t stat;

    // registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    // sequencer: owns the item handshake and orders every datapath step
    twlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: entry RAM, window compare, list walk, output beat register
    twlf_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .log_id      (log_id),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .entry_id    (entry_id),
        .entry_stamp (entry_stamp),
        .occupancy   (occupancy),
        .dropped     (dropped),
        .last        (last)
    );

endmodule
`default_nettype wire
